// ===== design/bcu_pkg.sv =====
`default_nettype none
package bcu_pkg;

  localparam int unsigned CntW  = 7;

  // Input operation and result kind codes.
  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;

  typedef enum logic {
    AOP_MUL,
    AOP_DIV
  } arith_op_t;

  typedef struct packed {
    logic             start;
    arith_op_t        op;
    logic [CntW-1:0]  nbits;
  } arith_ctl_t;

endpackage
`default_nettype wire

// ===== design/bcu_arith.sv =====
`default_nettype none
// Serial arithmetic unit: a signed-multiplier shift-add multiply that takes
// one multiplier bit per cycle (the top bit has negative weight, result wraps
// at 64 bits), and an unsigned restoring divide that takes one quotient bit
// per cycle.
module bcu_arith (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bcu_pkg::arith_ctl_t ctl,
  input  wire logic [63:0]         opa,
  input  wire logic [63:0]         opb,
  output logic [63:0]              result,
  output logic                     done,
  output logic                     busy
);
  import bcu_pkg::*;

  logic [63:0]     acc;
  logic [63:0]     mc;
  logic [63:0]     mp;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] last;
  arith_op_t       op;
  logic [64:0]     rem_sh;
  logic            fits;

  assign rem_sh = {acc, mp[63]};
  assign fits   = rem_sh >= {1'b0, mc};
  assign result = (op == AOP_DIV) ? mp : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= AOP_MUL;
      last <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        cnt  <= '0;
        last <= (ctl.op == AOP_DIV) ? CntW'(63) : ctl.nbits - CntW'(1);
        acc  <= '0;
        mc   <= (ctl.op == AOP_DIV) ? opb : opa;
        mp   <= (ctl.op == AOP_DIV) ? opa : opb;
      end else if (busy) begin
        unique case (op)
          AOP_MUL: begin
            if (mp[0]) begin
              acc <= (cnt == last) ? acc - mc : acc + mc;
            end
            mc <= {mc[62:0], 1'b0};
            mp <= {1'b0, mp[63:1]};
          end
          AOP_DIV: begin
            acc <= fits ? 64'(rem_sh - {1'b0, mc}) : rem_sh[63:0];
            mp  <= {mp[62:0], fits};
          end
          default: ;
        endcase
        cnt <= cnt + CntW'(1);
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("arith start while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("arith done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("arith done held two cycles");

endmodule
`default_nettype wire

// ===== design/baro_sensor_compensation_unit.sv =====
`default_nettype none
// Channel  | Direction | Handshake              | Word
// config   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
// sample   | in        | in_valid / in_stall    | op, raw_sample
// result   | out       | out_valid / out_stall  | kind, temperature_centi,
//          |           |                        | pressure_q24_8, zero_divisor
// A temperature word takes three serial multiplies of 16, 32 and 16 bits.
// A pressure word takes ten serial multiplies of 14 to 51 bits and one 64-bit
// divide, all on the single shared unit.
// A zero divisor ends a pressure word after the sixth multiply.
// Reset clears the coefficients, the fine temperature and all control state.
// A new sample is taken once the sequencer is idle, even while the previous
// result waits under out_stall; the last step waits for the output register.
module baro_sensor_compensation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [19:0] raw_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [31:0]      temperature_centi,
  output logic [31:0]      pressure_q24_8,
  output logic             zero_divisor
);
  import bcu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_T_A, S_T_B, S_T_C, S_T_OUT,
    S_P_SQ, S_P_V2A, S_P_V2B, S_P_V1A, S_P_V1B, S_P_V1C, S_P_NUM, S_P_DIV,
    S_P_H1, S_P_H2, S_P_V2, S_P_OUT, S_P_ZERO
  } state_t;

  state_t      state;
  logic        pend;
  logic [47:0] temp_coefs, press_coefs_a, press_coefs_b, press_coefs_c;
  logic [31:0] fine_temperature;
  logic [19:0] adc;
  logic [63:0] r_v1, r_v2, r_m, r_d, r_n, r_p;
  logic        q_neg;
  logic        out_load;

  arith_ctl_t  ctl;
  logic [63:0] opa, opb, prod;
  logic        done, busy;

  logic [31:0] t_x, t_b, t_fine, t_out, t_prod32;
  logic [63:0] v1w, h, sum, p_fin;

  bcu_arith u_arith (
    .clk(clk), .rst(rst), .ctl(ctl), .opa(opa), .opb(opb),
    .result(prod), .done(done), .busy(busy)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign out_load = ((state == S_T_OUT) || (state == S_P_OUT) || (state == S_P_ZERO))
                  && (!out_valid || !out_stall);

  assign t_x = 32'(adc[19:3]) - {15'b0, temp_coefs[15:0], 1'b0};
  assign t_b = 32'(adc[19:4]) - {16'b0, temp_coefs[15:0]};
  assign t_prod32 = 32'($signed(prod[31:0]) >>> 14);
  assign t_fine = 32'($signed(r_v1[31:0]) >>> 11) + t_prod32;
  assign t_out = 32'($signed(32'({fine_temperature, 2'b0}) + fine_temperature
                 + 32'd128) >>> 8);

  assign v1w = {{32{fine_temperature[31]}}, fine_temperature} - 64'd128000;
  assign h   = 64'($signed(r_p) >>> 13);
  assign sum = r_p + r_v1 + r_v2;
  assign p_fin = 64'($signed(sum) >>> 8)
               + {{44{press_coefs_c[15]}}, press_coefs_c[15:0], 4'b0};

  // Operand selection for the shared serial unit.
  always_comb begin
    ctl.start = (state != S_IDLE) && (state != S_T_OUT) && (state != S_P_OUT)
              && (state != S_P_ZERO) && !pend;
    ctl.op    = AOP_MUL;
    ctl.nbits = CntW'(16);
    opa = '0;
    opb = '0;
    unique case (state)
      S_T_A: begin
        opa = {32'b0, t_x};
        opb = {{48{temp_coefs[31]}}, temp_coefs[31:16]};
      end
      S_T_B: begin
        opa = {32'b0, t_b};
        opb = {32'b0, t_b};
        ctl.nbits = CntW'(32);
      end
      S_T_C: begin
        opa = {32'b0, 32'($signed(r_m[31:0]) >>> 12)};
        opb = {48'b0, temp_coefs[47:32]};
      end
      S_P_SQ: begin
        opa = v1w;
        opb = v1w;
        ctl.nbits = CntW'(34);
      end
      S_P_V2A: begin
        opa = r_m;
        opb = {48'b0, press_coefs_b[47:32]};
      end
      S_P_V2B: begin
        opa = v1w;
        opb = {48'b0, press_coefs_b[31:16]};
      end
      S_P_V1A: begin
        opa = r_m;
        opb = {48'b0, press_coefs_a[47:32]};
      end
      S_P_V1B: begin
        opa = v1w;
        opb = {48'b0, press_coefs_a[31:16]};
      end
      S_P_V1C: begin
        opa = 64'h0000_8000_0000_0000 + r_m;
        opb = {48'b0, press_coefs_a[15:0]};
        ctl.nbits = CntW'(17);
      end
      S_P_NUM: begin
        opa = {64'(21'd1048576 - 21'(adc)) << 31} - r_v2;
        opb = 64'd3125;
        ctl.nbits = CntW'(14);
      end
      S_P_DIV: begin
        ctl.op = AOP_DIV;
        opa = r_n[63] ? 64'(0 - r_n) : r_n;
        opb = r_d[63] ? 64'(0 - r_d) : r_d;
      end
      S_P_H1: begin
        opa = h;
        opb = {48'b0, press_coefs_c[47:32]};
      end
      S_P_H2: begin
        opa = r_m;
        opb = h;
        ctl.nbits = CntW'(51);
      end
      S_P_V2: begin
        opa = r_p;
        opb = {48'b0, press_coefs_c[31:16]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pend             <= 1'b0;
      out_valid        <= 1'b0;
      temp_coefs       <= '0;
      press_coefs_a    <= '0;
      press_coefs_b    <= '0;
      press_coefs_c    <= '0;
      fine_temperature <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TEMP:    temp_coefs    <= cfg_data;
          REG_PRESS_A: press_coefs_a <= cfg_data;
          REG_PRESS_B: press_coefs_b <= cfg_data;
          REG_PRESS_C: press_coefs_c <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (ctl.start) begin
        pend <= 1'b1;
      end
      if (done) begin
        pend <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            adc   <= raw_sample;
            state <= (op == OP_PRESS) ? S_P_SQ : S_T_A;
          end
        end
        S_T_A: if (done) begin
          r_v1  <= prod;
          state <= S_T_B;
        end
        S_T_B: if (done) begin
          r_m   <= prod;
          state <= S_T_C;
        end
        S_T_C: if (done) begin
          fine_temperature <= t_fine;
          state            <= S_T_OUT;
        end
        S_T_OUT: if (out_load) begin
          out_valid         <= 1'b1;
          kind              <= OP_TEMP;
          temperature_centi <= t_out;
          pressure_q24_8    <= '0;
          zero_divisor      <= 1'b0;
          state             <= S_IDLE;
        end
        S_P_SQ: if (done) begin
          r_m   <= prod;
          state <= S_P_V2A;
        end
        S_P_V2A: if (done) begin
          r_v2  <= prod;
          state <= S_P_V2B;
        end
        S_P_V2B: if (done) begin
          r_v2  <= r_v2 + {prod[46:0], 17'b0}
                 + {{13{press_coefs_b[15]}}, press_coefs_b[15:0], 35'b0};
          state <= S_P_V1A;
        end
        S_P_V1A: if (done) begin
          r_m   <= 64'($signed(prod) >>> 8);
          state <= S_P_V1B;
        end
        S_P_V1B: if (done) begin
          r_m   <= r_m + {prod[51:0], 12'b0};
          state <= S_P_V1C;
        end
        S_P_V1C: if (done) begin
          r_d   <= 64'($signed(prod) >>> 33);
          state <= (64'($signed(prod) >>> 33) == 64'd0) ? S_P_ZERO : S_P_NUM;
        end
        S_P_NUM: if (done) begin
          r_n   <= prod;
          q_neg <= prod[63] ^ r_d[63];
          state <= S_P_DIV;
        end
        S_P_DIV: if (done) begin
          r_p   <= q_neg ? 64'(0 - prod) : prod;
          state <= S_P_H1;
        end
        S_P_H1: if (done) begin
          r_m   <= prod;
          state <= S_P_H2;
        end
        S_P_H2: if (done) begin
          r_v1  <= 64'($signed(prod) >>> 25);
          state <= S_P_V2;
        end
        S_P_V2: if (done) begin
          r_v2  <= 64'($signed(prod) >>> 19);
          state <= S_P_OUT;
        end
        S_P_OUT: if (out_load) begin
          out_valid         <= 1'b1;
          kind              <= OP_PRESS;
          temperature_centi <= '0;
          pressure_q24_8    <= p_fin[31:0];
          zero_divisor      <= 1'b0;
          state             <= S_IDLE;
        end
        S_P_ZERO: if (out_load) begin
          out_valid         <= 1'b1;
          kind              <= OP_PRESS;
          temperature_centi <= '0;
          pressure_q24_8    <= '0;
          zero_divisor      <= 1'b1;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted sample did not start the sequencer");
  a_done_pending: assert property (@(posedge clk) disable iff (rst) done |-> pend)
    else $error("arith done without a pending operation");
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (kind == OP_PRESS && pressure_q24_8 == 32'd0))
    else $error("zero divisor flag on a nonzero or temperature result");
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy)
    else $error("arith unit busy while sequencer idle");

endmodule
`default_nettype wire
